[src/grv_pkg.sv]
// Package for the gain ramp volume block: widths, gain and sample constants,
// op codes, register indexes and the control status struct. No dependencies.
package grv_pkg;

   localparam int SampleWidth   = 16;
   localparam int TargetWidth   = 16;
   localparam int GainWidth     = 24;
   localparam int StepWidth     = 25;
   localparam int FracBits      = 23;
   localparam int ProductWidth  = SampleWidth + 1 + GainWidth;
   localparam int RampFramesDef = 256;

   localparam logic [GainWidth-1:0]   GainUnity   = 24'h800000;
   localparam logic [GainWidth-1:0]   GainMax     = 24'hFFFFFF;
   localparam logic [TargetWidth-1:0] TargetUnity = 16'h8000;

   localparam logic [SampleWidth-1:0] SampleMax = 16'h7FFF;
   localparam logic [SampleWidth-1:0] SampleMin = 16'h8000;

   // Operation codes carried by each input transfer.
   localparam logic OpFrame   = 1'b0;
   localparam logic OpSetGain = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CsrStereoMode = 2'd0;
   localparam logic [1:0] CsrIs16bit    = 2'd1;

   // Status handed from the gain controller to the datapath.
   typedef struct packed {
      logic [GainWidth-1:0] gain_use;
      logic                 ramp_active;
   } grv_status_type;

endpackage

[src/grv_scale.sv]
// Multiplies one signed 16-bit sample by the unsigned Q1.23 gain, truncates
// toward zero and saturates to int16. Depends on grv_pkg.
module grv_scale
   import grv_pkg::*;
(
   input  logic signed [SampleWidth-1:0] sample,
   input  logic        [GainWidth-1:0]   gain,
   output logic signed [SampleWidth-1:0] scaled
);

   logic                        neg;
   logic [SampleWidth:0]        mag;
   logic [ProductWidth-1:0]     product;
   logic [ProductWidth-FracBits-1:0] mag_shifted;

   always_comb begin
      neg         = sample[SampleWidth-1];
      mag         = neg ? (17'd0 - {sample[SampleWidth-1], sample})
                        : {1'b0, sample};
      product     = {{GainWidth{1'b0}}, mag} * {{(SampleWidth+1){1'b0}}, gain};
      mag_shifted = product[ProductWidth-1:FracBits];
      if (neg) begin
         if (mag_shifted > 18'd32768) begin
            scaled = SampleMin;
         end else begin
            scaled = SampleWidth'(18'd0 - mag_shifted);
         end
      end else begin
         if (mag_shifted > 18'd32767) begin
            scaled = SampleMax;
         end else begin
            scaled = SampleWidth'(mag_shifted);
         end
      end
   end

endmodule

[src/grv_ctrl.sv]
// Gain controller: holds the current gain, target, ramp step and frame
// count, and picks the gain that each frame uses. Depends on grv_pkg.
module grv_ctrl
   import grv_pkg::*;
#(
   parameter int RAMP_FRAMES = RampFramesDef
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic                   is_16bit,
   input  logic                   operation,
   input  logic [TargetWidth-1:0] new_gain,
   input  logic                   ramp_enable,
   output grv_status_type         status
);

   localparam int CountWidth = $clog2(RAMP_FRAMES + 1);
   localparam int RampShift  = CountWidth - 1;
   localparam logic [CountWidth-1:0] RampCount = CountWidth'(RAMP_FRAMES);

   logic [GainWidth-1:0]   gain_now_ff, gain_now_in;
   logic [TargetWidth-1:0] gain_target_ff, gain_target_in;
   logic signed [StepWidth-1:0] gain_step_ff, gain_step_in;
   logic [CountWidth-1:0]  frames_left_ff, frames_left_in;

   logic [GainWidth-1:0]        tgt_set;
   logic [GainWidth-1:0]        tgt_cur;
   logic signed [StepWidth-1:0] diff;
   logic [StepWidth-1:0]        diff_mag;
   logic [StepWidth-1:0]        step_mag;
   logic signed [StepWidth:0]   gain_next;

   always_comb begin
      tgt_set   = {new_gain, 8'd0};
      tgt_cur   = {gain_target_ff, 8'd0};
      diff      = $signed({1'b0, gain_now_ff}) - $signed({1'b0, tgt_set});
      diff_mag  = diff[StepWidth-1] ? StepWidth'(-diff) : StepWidth'(diff);
      step_mag  = diff_mag >> RampShift;
      gain_next = $signed({2'b00, gain_now_ff}) - $signed({gain_step_ff[StepWidth-1],
                                                             gain_step_ff});

      gain_now_in        = gain_now_ff;
      gain_target_in     = gain_target_ff;
      gain_step_in       = gain_step_ff;
      frames_left_in     = frames_left_ff;
      status.gain_use    = tgt_cur;
      status.ramp_active = 1'b0;

      if (operation == OpSetGain) begin
         gain_target_in = new_gain;
         if (tgt_set == gain_now_ff) begin
            frames_left_in = '0;
            gain_step_in   = '0;
         end else if (ramp_enable) begin
            gain_step_in   = diff[StepWidth-1] ? $signed(-step_mag) : $signed(step_mag);
            frames_left_in = RampCount;
         end else begin
            gain_now_in    = tgt_set;
            frames_left_in = '0;
            gain_step_in   = '0;
         end
      end else if (is_16bit) begin
         if (frames_left_ff != '0 && gain_now_ff != tgt_cur) begin
            status.gain_use    = gain_now_ff;
            status.ramp_active = 1'b1;
            // Clamp the stepped gain to the unsigned 24-bit range.
            if (gain_next[StepWidth]) begin
               gain_now_in = '0;
            end else if (gain_next[StepWidth-1]) begin
               gain_now_in = GainMax;
            end else begin
               gain_now_in = gain_next[GainWidth-1:0];
            end
            frames_left_in = frames_left_ff - CountWidth'(1);
         end else begin
            frames_left_in = '0;
            gain_now_in    = tgt_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_now_ff    <= GainUnity;
         gain_target_ff <= TargetUnity;
         gain_step_ff   <= '0;
         frames_left_ff <= '0;
      end else if (fire) begin
         gain_now_ff    <= gain_now_in;
         gain_target_ff <= gain_target_in;
         gain_step_ff   <= gain_step_in;
         frames_left_ff <= frames_left_in;
      end
   end

endmodule

[src/gain_ramp_volume_top.sv]
// An accepted frame transfer passes through the input register and then the
// result register. Throughput: one item per cycle while no waiting result is
// stalled; a set-gain item takes one slot, no result. The rate is set by one pass
// of the gain controller and the two scalers between the two registers.
// Reset (synchronous, active high) empties both registers, sets unity gain,
// clears the ramp and restores mono, 16-bit mode.
module gain_ramp_volume_top
   import grv_pkg::*;
#(
   parameter int RAMP_FRAMES = RampFramesDef
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic signed [SampleWidth-1:0] req_sample_left,
   input  logic signed [SampleWidth-1:0] req_sample_right,
   input  logic                          req_end_of_block,
   input  logic [TargetWidth-1:0]        req_new_gain,
   input  logic                          req_ramp_enable,
   // Result channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SampleWidth-1:0] rsp_out_left,
   output logic signed [SampleWidth-1:0] rsp_out_right,
   output logic                          rsp_ramp_active,
   output logic                          rsp_end_of_block_out,
   // Configuration write channel.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic                          csr_wdata
);

   // The whole pipe moves together; it halts only while a finished result
   // waits in the result register and the consumer stalls it.
   logic advance;

   logic stereo_mode_ff, is_16bit_ff;

   logic                          s1_valid_ff;
   logic                          s1_operation_ff;
   logic signed [SampleWidth-1:0] s1_left_ff, s1_right_ff;
   logic                          s1_eob_ff;
   logic [TargetWidth-1:0]        s1_new_gain_ff;
   logic                          s1_ramp_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SampleWidth-1:0] out_left_ff, out_left_in;
   logic signed [SampleWidth-1:0] out_right_ff, out_right_in;
   logic                          ramp_active_ff;
   logic                          eob_out_ff;

   grv_status_type                status;
   logic signed [SampleWidth-1:0] scaled_left, scaled_right;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // Configuration registers. Writes to indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_mode_ff <= 1'b0;
         is_16bit_ff    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrStereoMode: stereo_mode_ff <= csr_wdata;
            CsrIs16bit:    is_16bit_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input register: every accepted transfer lands here.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_operation_ff <= req_operation;
         s1_left_ff      <= req_sample_left;
         s1_right_ff     <= req_sample_right;
         s1_eob_ff       <= req_end_of_block;
         s1_new_gain_ff  <= req_new_gain;
         s1_ramp_ff      <= req_ramp_enable;
      end
   end

   // The gain controller updates its state once per item as it leaves the
   // input register, and reports the gain that the frame uses.
   grv_ctrl #(
      .RAMP_FRAMES (RAMP_FRAMES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance && s1_valid_ff),
      .is_16bit    (is_16bit_ff),
      .operation   (s1_operation_ff),
      .new_gain    (s1_new_gain_ff),
      .ramp_enable (s1_ramp_ff),
      .status      (status)
   );

   grv_scale u_scale_left (
      .sample (s1_left_ff),
      .gain   (status.gain_use),
      .scaled (scaled_left)
   );

   grv_scale u_scale_right (
      .sample (s1_right_ff),
      .gain   (status.gain_use),
      .scaled (scaled_right)
   );

   // In 8-bit mode the samples bypass the scalers. The right output reads
   // zero in mono mode either way.
   always_comb begin
      rsp_valid_in = s1_valid_ff && (s1_operation_ff == OpFrame);
      if (is_16bit_ff) begin
         out_left_in  = scaled_left;
         out_right_in = stereo_mode_ff ? scaled_right : '0;
      end else begin
         out_left_in  = s1_left_ff;
         out_right_in = stereo_mode_ff ? s1_right_ff : '0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_left_ff    <= out_left_in;
         out_right_ff   <= out_right_in;
         ramp_active_ff <= status.ramp_active && is_16bit_ff;
         eob_out_ff     <= s1_eob_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_left         = out_left_ff;
   assign rsp_out_right        = out_right_ff;
   assign rsp_ramp_active      = ramp_active_ff;
   assign rsp_end_of_block_out = eob_out_ff;

endmodule

[src/grv_checker.sv]
// Port-level checker for gain_ramp_volume_top and the bind that attaches it.
// Depends on grv_pkg and the top level's ports.
module grv_checker
   import grv_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SampleWidth-1:0] rsp_out_left,
   input logic signed [SampleWidth-1:0] rsp_out_right,
   input logic                          rsp_ramp_active,
   input logic                          rsp_end_of_block_out
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_left)
         && $stable(rsp_out_right) && $stable(rsp_ramp_active)
         && $stable(rsp_end_of_block_out))
      else $error("stalled result changed");

   // The input side stalls exactly when a waiting result is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow result stall");

   // Reset empties the result register.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A fresh result comes from an earlier accepted transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) && !$past(reset) && !$past(reset, 2)
         |-> $past(req_valid && !req_stall, 2))
      else $error("result without an accepted transfer");

endmodule

bind gain_ramp_volume_top grv_checker u_grv_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_out_left         (rsp_out_left),
   .rsp_out_right        (rsp_out_right),
   .rsp_ramp_active      (rsp_ramp_active),
   .rsp_end_of_block_out (rsp_end_of_block_out)
);

[tb/gain_ramp_volume_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for gain_ramp_volume_top: a scoreboard class that predicts
// every frame result, plus tasks that drive the request and register write channels.
// Depends on grv_pkg and the gain_ramp_volume_top RTL.

import grv_pkg::*;

localparam int RampFrames = RampFramesDef;
// floor(log2(RampFrames)) sets how far the ramp difference is shifted down.
localparam int RampShift  = $clog2(RampFrames + 1) - 1;
localparam int GainPad    = GainWidth - TargetWidth;

typedef struct packed {
   logic                          operation;
   logic signed [SampleWidth-1:0] left;
   logic signed [SampleWidth-1:0] right;
   logic                          end_of_block;
   logic [TargetWidth-1:0]        new_gain;
   logic                          ramp_enable;
} volume_req_type;

typedef struct packed {
   logic signed [SampleWidth-1:0] left;
   logic signed [SampleWidth-1:0] right;
   logic                          ramp_active;
   logic                          end_of_block;
} volume_frame_type;

class gain_scoreboard;
   logic                   stereo_mode;
   logic                   is_16bit;
   logic [GainWidth-1:0]   gain_now;
   logic [TargetWidth-1:0] gain_target;
   int                     gain_step;
   int                     frames_left;
   volume_frame_type       expected_frames[$];
   int                     mismatches;
   int                     frames_checked;
   int                     ramp_frames;
   int                     gain_updates;

   function new();
      stereo_mode    = 1'b0;
      is_16bit       = 1'b1;
      gain_now       = GainUnity;
      gain_target    = TargetUnity;
      gain_step      = 0;
      frames_left    = 0;
      mismatches     = 0;
      frames_checked = 0;
      ramp_frames    = 0;
      gain_updates   = 0;
   endfunction

   function void write_register(logic [1:0] index, logic value);
      if (index == CsrStereoMode)
         stereo_mode = value;
      else if (index == CsrIs16bit)
         is_16bit = value;
   endfunction

   // Magnitude times gain, truncated toward zero, then clamped to int16.
   function logic signed [SampleWidth-1:0] scale_sample(logic signed [SampleWidth-1:0] s,
                                                        logic [GainWidth-1:0] g);
      longint mag;
      mag = (s < 0) ? -longint'(s) : longint'(s);
      mag = (mag * longint'(g)) >> FracBits;
      if (s < 0) begin
         if (mag > 32768)
            return SampleMin;
         mag = -mag;
         return mag[SampleWidth-1:0];
      end
      if (mag > 32767)
         return SampleMax;
      return mag[SampleWidth-1:0];
   endfunction

   function void note_request(volume_req_type req);
      logic [GainWidth-1:0] target_gain;
      int                   diff;
      int                   mag;
      longint               next_gain;
      volume_frame_type     f;
      if (req.operation == OpSetGain) begin
         gain_updates++;
         target_gain = {req.new_gain, {GainPad{1'b0}}};
         gain_target = req.new_gain;
         if (target_gain == gain_now) begin
            frames_left = 0;
            gain_step   = 0;
         end else if (req.ramp_enable) begin
            diff        = int'(gain_now) - int'(target_gain);
            mag         = ((diff < 0) ? -diff : diff) >> RampShift;
            gain_step   = (diff < 0) ? -mag : mag;
            frames_left = RampFrames;
         end else begin
            gain_now    = target_gain;
            frames_left = 0;
            gain_step   = 0;
         end
         return;
      end
      f.end_of_block = req.end_of_block;
      f.ramp_active  = 1'b0;
      if (!is_16bit) begin
         f.left  = req.left;
         f.right = stereo_mode ? req.right : '0;
      end else begin
         target_gain = {gain_target, {GainPad{1'b0}}};
         if (frames_left != 0 && gain_now != target_gain) begin
            f.ramp_active = 1'b1;
            f.left        = scale_sample(req.left, gain_now);
            f.right       = stereo_mode ? scale_sample(req.right, gain_now) : '0;
            next_gain     = longint'(gain_now) - longint'(gain_step);
            if (next_gain < 0)
               next_gain = 0;
            if (next_gain > longint'(GainMax))
               next_gain = longint'(GainMax);
            gain_now = next_gain[GainWidth-1:0];
            frames_left--;
         end else begin
            frames_left = 0;
            gain_now    = target_gain;
            f.left      = scale_sample(req.left, gain_now);
            f.right     = stereo_mode ? scale_sample(req.right, gain_now) : '0;
         end
      end
      expected_frames.push_back(f);
   endfunction

   function void check_frame(volume_frame_type got);
      volume_frame_type want;
      if (expected_frames.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result transfer with nothing expected: left %0d right %0d",
                     $time, $signed(got.left), $signed(got.right));
         return;
      end
      want = expected_frames.pop_front();
      frames_checked++;
      if (want.ramp_active)
         ramp_frames++;
      if (got.left !== want.left || got.right !== want.right ||
          got.ramp_active !== want.ramp_active || got.end_of_block !== want.end_of_block) begin
         mismatches++;
         if (mismatches <= 10)
            $display(
               "%0t: mismatch: expected %0d/%0d ramp %0b eob %0b, got %0d/%0d ramp %0b eob %0b",
               $time, $signed(want.left), $signed(want.right), want.ramp_active,
               want.end_of_block, $signed(got.left), $signed(got.right),
               got.ramp_active, got.end_of_block);
      end
   endfunction
endclass

module gain_ramp_volume_top_tb;

   localparam int ResetCycles   = 11;
   // Extra cycles to wait once no frame is expected, to cover an in-flight
   // set-gain.
   localparam int SettleCycles  = 4;
   localparam int DrainCycles   = 8;
   localparam int HoldCycles    = 64;
   localparam int WatchdogLimit = 1000;
   localparam int IdlePercent   = 12;
   localparam int StallPercent  = 20;
   localparam int PhaseCount    = 6;

   // Each random phase runs under its own register setting. Phases with no random
   // set-gain items open with one ramp, which no later set-gain cuts short.
   localparam bit PhaseStereo [PhaseCount] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
   localparam bit Phase16bit  [PhaseCount] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
   localparam int PhaseItems  [PhaseCount] = '{300, 150, 300, 150, 300, 150};
   localparam int PhaseGainPct[PhaseCount] = '{0, 15, 0, 15, 15, 0};

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_operation = OpFrame;
   logic signed [SampleWidth-1:0] req_sample_left = '0;
   logic signed [SampleWidth-1:0] req_sample_right = '0;
   logic                          req_end_of_block = 1'b0;
   logic [TargetWidth-1:0]        req_new_gain = '0;
   logic                          req_ramp_enable = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SampleWidth-1:0] rsp_out_left;
   logic signed [SampleWidth-1:0] rsp_out_right;
   logic                          rsp_ramp_active;
   logic                          rsp_end_of_block_out;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [1:0]                    csr_index = '0;
   logic                          csr_wdata = 1'b0;

   gain_scoreboard   scoreboard = new();
   volume_req_type   seen_req;
   volume_frame_type seen_frame;

   // When tx_calm or rx_calm is set, that side never idles on its own.
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;
   // Asks the receiver to hold off for a long stretch while items keep coming.
   bit hold_request = 1'b0;
   int idle_cycles = 0;
   int settings_used = 0;

   gain_ramp_volume_top #(
      .RAMP_FRAMES (RampFrames)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_sample_left      (req_sample_left),
      .req_sample_right     (req_sample_right),
      .req_end_of_block     (req_end_of_block),
      .req_new_gain         (req_new_gain),
      .req_ramp_enable      (req_ramp_enable),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_left         (rsp_out_left),
      .rsp_out_right        (rsp_out_right),
      .rsp_ramp_active      (rsp_ramp_active),
      .rsp_end_of_block_out (rsp_end_of_block_out),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The monitor samples both channels at the rising edge. All inputs are driven
   // with nonblocking assignments at that same edge, so the values seen here are
   // the ones that the block saw. A result transfer is checked before the input
   // transfer of the same edge is noted; the two can never belong together,
   // since a frame passes the input register and then the result register.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen_frame.left         = rsp_out_left;
            seen_frame.right        = rsp_out_right;
            seen_frame.ramp_active  = rsp_ramp_active;
            seen_frame.end_of_block = rsp_end_of_block_out;
            scoreboard.check_frame(seen_frame);
         end
         if (req_valid && !req_stall) begin
            seen_req.operation    = req_operation;
            seen_req.left         = req_sample_left;
            seen_req.right        = req_sample_right;
            seen_req.end_of_block = req_end_of_block;
            seen_req.new_gain     = req_new_gain;
            seen_req.ramp_enable  = req_ramp_enable;
            scoreboard.note_request(seen_req);
         end
      end
   end

   // The watchdog counts cycles in which no transfer happens on any channel.
   // Its limit is well above the longest legal pause: the receiver hold-off.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("FAIL gain_ramp_volume_top");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: stalls at random in about one cycle of five, except during the
   // calm stretch. On request it holds off for HoldCycles cycles, counted here,
   // so that both pipeline stages fill and the block stalls its input.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            rsp_stall <= !rx_calm && ($urandom_range(0, 99) < StallPercent);
         end
      end
   end

   // Mostly random samples, with the two extremes and tiny values mixed in.
   function automatic logic [SampleWidth-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return SampleMin;
         1:       return SampleMax;
         2:       return SampleWidth'($urandom_range(0, 3)) - SampleWidth'(2);
         default: return SampleWidth'($urandom);
      endcase
   endfunction

   function automatic volume_req_type frame_req(logic [SampleWidth-1:0] left,
                                                logic [SampleWidth-1:0] right, logic eob);
      volume_req_type r;
      r.operation    = OpFrame;
      r.left         = left;
      r.right        = right;
      r.end_of_block = eob;
      // The gain fields are ignored on a frame, so they carry noise.
      r.new_gain     = TargetWidth'($urandom);
      r.ramp_enable  = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic volume_req_type gain_req(logic [TargetWidth-1:0] gain, logic ramp);
      volume_req_type r;
      r.operation    = OpSetGain;
      r.left         = SampleWidth'($urandom);
      r.right        = SampleWidth'($urandom);
      r.end_of_block = 1'($urandom_range(0, 1));
      r.new_gain     = gain;
      r.ramp_enable  = ramp;
      return r;
   endfunction

   function automatic volume_req_type random_req(int gain_pct);
      logic [TargetWidth-1:0] g;
      if ($urandom_range(0, 99) >= gain_pct)
         return frame_req(random_sample(), random_sample(), 1'($urandom_range(0, 1)));
      case ($urandom_range(0, 7))
         0:       g = '0;
         1:       g = '1;
         2:       g = TargetUnity;
         3:       g = scoreboard.gain_now[GainWidth-1 -: TargetWidth];
         4:       g = scoreboard.gain_target + TargetWidth'(1);
         default: g = TargetWidth'($urandom);
      endcase
      return gain_req(g, $urandom_range(0, 3) != 0);
   endfunction

   // Offers one item and returns at the edge where it is transferred. Valid is
   // left high, so back-to-back items need no second assignment in one step.
   task automatic send_item(volume_req_type item);
      if (!tx_calm && $urandom_range(0, 99) < IdlePercent) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_operation    <= item.operation;
      req_sample_left  <= item.left;
      req_sample_right <= item.right;
      req_end_of_block <= item.end_of_block;
      req_new_gain     <= item.new_gain;
      req_ramp_enable  <= item.ramp_enable;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Drops valid, waits for every expected frame, then lets a possible set-gain
   // item clear the pipeline before the block is treated as idle.
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (scoreboard.expected_frames.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic value);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      scoreboard.write_register(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(logic stereo, logic gain_on);
      wait_for_quiet();
      write_register(CsrStereoMode, stereo);
      write_register(CsrIs16bit, gain_on);
      settings_used++;
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part in mono with gain applied: unity gain on the sample
      // extremes, a jump to full gain that saturates both ways, a jump to zero,
      // a set-gain equal to the current gain, and a ramp that is re-targeted
      // after three frames and then cut short by a jump.
      set_mode(1'b0, 1'b1);
      send_item(frame_req(SampleMax, 16'h0000, 1'b0));
      send_item(frame_req(SampleMin, SampleMax, 1'b1));
      send_item(frame_req(16'h0000, 16'hFFFF, 1'b0));
      send_item(frame_req(16'hFFFF, 16'h0001, 1'b0));
      send_item(gain_req(16'hFFFF, 1'b0));
      send_item(frame_req(SampleMax, SampleMin, 1'b0));
      send_item(frame_req(SampleMin, SampleMax, 1'b0));
      send_item(frame_req(16'd12345, 16'd54321, 1'b1));
      send_item(gain_req(16'h0000, 1'b0));
      send_item(frame_req(SampleMin, SampleMax, 1'b0));
      send_item(gain_req(16'h0000, 1'b1));
      send_item(frame_req(16'd1000, 16'd2000, 1'b0));
      send_item(gain_req(TargetUnity, 1'b1));
      send_item(frame_req(SampleMax, SampleMin, 1'b1));
      send_item(frame_req(SampleMin, SampleMax, 1'b0));
      send_item(frame_req(16'hFFFF, 16'h0001, 1'b0));
      send_item(gain_req(16'h4000, 1'b1));
      send_item(frame_req(16'd20000, 16'd3, 1'b0));
      send_item(frame_req(-16'sd20000, 16'd7, 1'b0));
      send_item(gain_req(16'h4000, 1'b0));
      send_item(frame_req(16'd30000, 16'd9, 1'b1));

      // Stereo with gain, then the pass-through mode in stereo and in mono.
      set_mode(1'b1, 1'b1);
      send_item(frame_req(SampleMax, SampleMin, 1'b0));
      send_item(frame_req(SampleMin, SampleMax, 1'b1));
      set_mode(1'b1, 1'b0);
      send_item(frame_req(SampleMin, SampleMax, 1'b0));
      set_mode(1'b0, 1'b0);
      send_item(frame_req(16'd5, -16'sd5, 1'b1));

      // Random phases. Phase two runs with no idling on either side; phase four
      // holds off the receiver for a long stretch partway through.
      for (int phase = 0; phase < PhaseCount; phase++) begin
         set_mode(PhaseStereo[phase], Phase16bit[phase]);
         tx_calm = (phase == 2);
         rx_calm = (phase == 2);
         if (PhaseGainPct[phase] == 0)
            send_item(gain_req(TargetWidth'($urandom), 1'b1));
         for (int n = 0; n < PhaseItems[phase]; n++) begin
            if (phase == 4 && n == 100)
               hold_request = 1'b1;
            send_item(random_req(PhaseGainPct[phase]));
         end
      end
      tx_calm = 1'b0;
      rx_calm = 1'b0;

      wait_for_quiet();
      repeat (DrainCycles) @(posedge clock);

      $display("Checked %0d frames, %0d of them on a ramp, with %0d gain updates",
               scoreboard.frames_checked, scoreboard.ramp_frames, scoreboard.gain_updates);
      $display("over %0d register settings; %0d mismatches.", settings_used,
               scoreboard.mismatches);
      if (scoreboard.mismatches == 0 && scoreboard.expected_frames.size() == 0)
         $display("PASS gain_ramp_volume_top");
      else
         $display("FAIL gain_ramp_volume_top");
      $finish;
   end

endmodule

[sim.f]
src/grv_pkg.sv
src/grv_scale.sv
src/grv_ctrl.sv
src/gain_ramp_volume_top.sv
src/grv_checker.sv
tb/gain_ramp_volume_top_tb.sv
